### design/sdgf_pkg.sv
// Package: shared constants, codes, state and command/status types for the gap filler.
`default_nettype none
package sdgf_pkg;

	localparam int unsigned MAX_PADDING = 63;
	localparam int unsigned PAD_W       = $clog2(MAX_PADDING + 1);

	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned PERIOD_W = 17;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned CFG_W    = 17;
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned DIV_STEPS = VALUE_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [VALUE_W-1:0]  MARKER_VALUE   = {VALUE_W{1'b1}};
	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(60);
	localparam logic [MODE_W-1:0]   MODE_RESET     = 2'd0;

	localparam logic [MODE_W-1:0] MODE_RAW      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RATE     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELTA    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSABLE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_GAP_DIV,
		ST_PAD,
		ST_DELTA,
		ST_DELTA_DIV,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic load;
		logic gap_div_start;
		logic gap_latch;
		logic pad_emit;
		logic delta_latch;
		logic delta_div_start;
		logic delta_div_latch;
		logic final_emit;
	} cmd_t;

	typedef struct packed {
		logic t_zero;
		logic gap_check;
		logic div_done;
		logic pad_left;
		logic out_free;
		logic need_div;
	} status_t;

endpackage
`default_nettype wire

### design/sdgf_div.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module sdgf_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sdgf_pkg::VALUE_W-1:0] dividend,
	input  wire logic [sdgf_pkg::TIME_W-1:0]  divisor,
	output logic                              done,
	output logic [sdgf_pkg::VALUE_W-1:0]      quotient
);

	logic [sdgf_pkg::VALUE_W-1:0]   quo_q;
	logic [sdgf_pkg::TIME_W-1:0]    rem_q;
	logic [sdgf_pkg::TIME_W-1:0]    dvs_q;
	logic [sdgf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [sdgf_pkg::TIME_W:0]      trial;
	logic [sdgf_pkg::TIME_W:0]      diff;
	logic                           ge;

	assign trial = {rem_q, quo_q[sdgf_pkg::VALUE_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= sdgf_pkg::DIV_CNT_W'(sdgf_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == sdgf_pkg::DIV_CNT_W'(1));
			end
		end
	end

	// operands are captured at start; the divisor is held for the whole division
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[sdgf_pkg::VALUE_W-2:0], ge};
			rem_q <= ge ? diff[sdgf_pkg::TIME_W-1:0] : trial[sdgf_pkg::TIME_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### design/sdgf_datapath.sv
// Datapath: configuration, series state, gap and delta arithmetic, result register.
`default_nettype none
module sdgf_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sdgf_pkg::cmd_t                 cmd,
	output sdgf_pkg::status_t                   status,
	input  wire logic                           cfg_we,
	input  wire logic [sdgf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sdgf_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                           series_start,
	input  wire logic [sdgf_pkg::TIME_W-1:0]    sample_time,
	input  wire logic [sdgf_pkg::VALUE_W-1:0]   sample_value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [sdgf_pkg::VALUE_W-1:0]        out_value,
	output logic                                is_marker,
	output logic                                is_padding,
	output logic                                pad_capped,
	output logic                                last_of_run
);

	logic [sdgf_pkg::MODE_W-1:0]   delta_mode_q;
	logic [sdgf_pkg::PERIOD_W-1:0] sample_period_q;
	logic [sdgf_pkg::PERIOD_W-1:0] period_eff;

	logic [sdgf_pkg::TIME_W-1:0]  t_q;
	logic [sdgf_pkg::VALUE_W-1:0] v_q;
	logic [sdgf_pkg::TIME_W-1:0]  prev_time_q;
	logic                         have_time_q;
	logic [sdgf_pkg::VALUE_W-1:0] prev_raw_q;
	logic                         prev_valid_q;

	logic [sdgf_pkg::PAD_W-1:0]   pad_cnt_q;
	logic                         capped_q;
	logic                         ok_q;
	logic [sdgf_pkg::VALUE_W-1:0] res_q;

	logic                         out_valid_q;
	logic [sdgf_pkg::VALUE_W-1:0] out_value_q;
	logic                         is_marker_q;
	logic                         is_padding_q;
	logic                         pad_capped_q;
	logic                         last_of_run_q;

	logic                         earlier;
	logic [sdgf_pkg::TIME_W-1:0]  step;
	logic [sdgf_pkg::VALUE_W-1:0] delta;
	logic                         formable;
	logic                         div_start;
	logic [sdgf_pkg::VALUE_W-1:0] div_dividend;
	logic [sdgf_pkg::TIME_W-1:0]  div_divisor;
	logic                         div_done;
	logic [sdgf_pkg::VALUE_W-1:0] quotient;
	logic [sdgf_pkg::VALUE_W-1:0] q_minus1;
	logic                         q_gt1;
	logic                         q_capped;
	logic                         ok_next;
	logic [sdgf_pkg::VALUE_W-1:0] res_next;

	assign period_eff = (sample_period_q == '0) ? sdgf_pkg::PERIOD_W'(1) : sample_period_q;
	assign earlier    = have_time_q && (t_q < prev_time_q);
	assign step       = t_q - prev_time_q;
	assign delta      = v_q - prev_raw_q;
	assign formable   = prev_valid_q && (prev_raw_q <= v_q);

	assign div_start    = cmd.gap_div_start || cmd.delta_div_start;
	assign div_dividend = cmd.delta_div_start ? delta : sdgf_pkg::VALUE_W'(step);
	assign div_divisor  = cmd.delta_div_start ? step : sdgf_pkg::TIME_W'(period_eff);

	sdgf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	assign q_gt1    = quotient > sdgf_pkg::VALUE_W'(1);
	assign q_capped = quotient > sdgf_pkg::VALUE_W'(sdgf_pkg::MAX_PADDING + 1);
	assign q_minus1 = quotient - 1'b1;

	always_comb begin
		ok_next  = 1'b0;
		res_next = v_q;
		unique case (delta_mode_q)
			sdgf_pkg::MODE_RAW: begin
				ok_next  = 1'b1;
				res_next = v_q;
			end
			sdgf_pkg::MODE_RATE: begin
				ok_next  = formable && have_time_q && (step != '0);
				res_next = delta;
			end
			sdgf_pkg::MODE_DELTA: begin
				ok_next  = formable;
				res_next = delta;
			end
			sdgf_pkg::MODE_UNUSABLE: begin
				ok_next  = 1'b0;
				res_next = v_q;
			end
			default: begin
				ok_next  = 1'b0;
				res_next = v_q;
			end
		endcase
		if (earlier) begin
			ok_next = 1'b0;
		end
	end

	always_comb begin
		status.t_zero    = (t_q == '0);
		status.gap_check = have_time_q && !earlier;
		status.div_done  = div_done;
		status.pad_left  = (pad_cnt_q != '0);
		status.out_free  = !out_valid_q || !out_stall;
		status.need_div  = ok_next && (delta_mode_q == sdgf_pkg::MODE_RATE);
	end

	// configuration and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_mode_q    <= sdgf_pkg::MODE_RESET;
			sample_period_q <= sdgf_pkg::PERIOD_RESET;
			have_time_q     <= 1'b0;
			prev_valid_q    <= 1'b0;
			prev_time_q     <= '0;
			prev_raw_q      <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sdgf_pkg::CFG_DELTA_MODE:
						delta_mode_q <= cfg_wdata[sdgf_pkg::MODE_W-1:0];
					sdgf_pkg::CFG_SAMPLE_PERIOD:
						sample_period_q <= cfg_wdata[sdgf_pkg::PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load && series_start) begin
				have_time_q  <= 1'b0;
				prev_valid_q <= 1'b0;
			end
			if (cmd.gap_latch && q_gt1) begin
				prev_valid_q <= 1'b0;
			end
			if (cmd.final_emit) begin
				prev_time_q  <= t_q;
				have_time_q  <= 1'b1;
				prev_valid_q <= ok_q;
				if (ok_q) begin
					prev_raw_q <= v_q;
				end
			end
			if (cmd.pad_emit || cmd.final_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-transaction working registers and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q       <= sample_time;
			v_q       <= sample_value;
			pad_cnt_q <= '0;
			capped_q  <= 1'b0;
		end
		if (cmd.gap_latch && q_gt1) begin
			capped_q  <= q_capped;
			pad_cnt_q <= q_capped ? sdgf_pkg::PAD_W'(sdgf_pkg::MAX_PADDING)
			                      : q_minus1[sdgf_pkg::PAD_W-1:0];
		end
		if (cmd.pad_emit) begin
			pad_cnt_q <= pad_cnt_q - 1'b1;
		end
		if (cmd.delta_latch) begin
			ok_q  <= ok_next;
			res_q <= res_next;
		end
		if (cmd.delta_div_latch) begin
			res_q <= quotient;
		end
		if (cmd.pad_emit) begin
			out_value_q   <= sdgf_pkg::MARKER_VALUE;
			is_marker_q   <= 1'b1;
			is_padding_q  <= 1'b1;
			pad_capped_q  <= capped_q;
			last_of_run_q <= 1'b0;
		end else if (cmd.final_emit) begin
			out_value_q   <= ok_q ? res_q : sdgf_pkg::MARKER_VALUE;
			is_marker_q   <= !ok_q;
			is_padding_q  <= 1'b0;
			pad_capped_q  <= capped_q;
			last_of_run_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_value   = out_value_q;
	assign is_marker   = is_marker_q;
	assign is_padding  = is_padding_q;
	assign pad_capped  = pad_capped_q;
	assign last_of_run = last_of_run_q;

endmodule
`default_nettype wire

### design/sdgf_ctrl.sv
// Controller: sequences load, gap division, padding, delta and final result.
`default_nettype none
module sdgf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sdgf_pkg::status_t status,
	output sdgf_pkg::cmd_t         cmd
);

	sdgf_pkg::state_t state_q;
	sdgf_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdgf_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			sdgf_pkg::ST_IDLE: begin
				if (in_valid) state_next = sdgf_pkg::ST_DECIDE;
			end
			sdgf_pkg::ST_DECIDE: begin
				if (status.t_zero) state_next = sdgf_pkg::ST_IDLE;
				else if (status.gap_check) state_next = sdgf_pkg::ST_GAP_DIV;
				else state_next = sdgf_pkg::ST_DELTA;
			end
			sdgf_pkg::ST_GAP_DIV: begin
				if (status.div_done) state_next = sdgf_pkg::ST_PAD;
			end
			sdgf_pkg::ST_PAD: begin
				if (!status.pad_left) state_next = sdgf_pkg::ST_DELTA;
			end
			sdgf_pkg::ST_DELTA: begin
				if (status.need_div) state_next = sdgf_pkg::ST_DELTA_DIV;
				else state_next = sdgf_pkg::ST_FINAL;
			end
			sdgf_pkg::ST_DELTA_DIV: begin
				if (status.div_done) state_next = sdgf_pkg::ST_FINAL;
			end
			sdgf_pkg::ST_FINAL: begin
				if (status.out_free) state_next = sdgf_pkg::ST_IDLE;
			end
			default: state_next = sdgf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			sdgf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			sdgf_pkg::ST_DECIDE: begin
				cmd.gap_div_start = !status.t_zero && status.gap_check;
			end
			sdgf_pkg::ST_GAP_DIV: begin
				cmd.gap_latch = status.div_done;
			end
			sdgf_pkg::ST_PAD: begin
				cmd.pad_emit = status.pad_left && status.out_free;
			end
			sdgf_pkg::ST_DELTA: begin
				cmd.delta_latch     = 1'b1;
				cmd.delta_div_start = status.need_div;
			end
			sdgf_pkg::ST_DELTA_DIV: begin
				cmd.delta_div_latch = status.div_done;
			end
			sdgf_pkg::ST_FINAL: begin
				cmd.final_emit = status.out_free;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### design/sample_delta_gap_filler.sv
// Top level: sample delta stage with gap padding markers.
// One sample transaction is taken at a time. A sample with zero time gives no result.
// Otherwise a sample runs the gap division and the padding check (when a previous time
// exists and the new time is not earlier), then emits its padding markers (0 to
// MAX_PADDING), then runs the delta step, with a second division in rate mode when the rate
// is formed, and then emits its final result. Both divisions run on one shared radix-2
// divider that retires one quotient bit per cycle. Results leave through an output
// register, so a final result may wait there while the next sample is taken; a stalled
// output holds back padding and final results.
`default_nettype none
module sample_delta_gap_filler (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sdgf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sdgf_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           series_start,
	input  wire logic [sdgf_pkg::TIME_W-1:0]    sample_time,
	input  wire logic [sdgf_pkg::VALUE_W-1:0]   sample_value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [sdgf_pkg::VALUE_W-1:0]        out_value,
	output logic                                is_marker,
	output logic                                is_padding,
	output logic                                pad_capped,
	output logic                                last_of_run
);

	sdgf_pkg::cmd_t    cmd;
	sdgf_pkg::status_t status;

	sdgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sdgf_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.series_start (series_start),
		.sample_time  (sample_time),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_value    (out_value),
		.is_marker    (is_marker),
		.is_padding   (is_padding),
		.pad_capped   (pad_capped),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire
